// ----- rtl/dtdc_pkg.sv -----
// shared types, constants and calendar tables for the date text parser
`default_nettype none

package dtdc_pkg;

  // characters in one full date and time field, MM/DD/YY HH:MM:SS
  localparam int unsigned TEXT_FIELD_CHARS = 17;
  localparam int unsigned POS_W            = 5;
  localparam int unsigned DIGITS           = 12;
  localparam int unsigned DIGIT_IDX_W      = 4;

  // character codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // separator positions within the field
  localparam logic [POS_W-1:0] POS_SLASH_A = 5'd2;
  localparam logic [POS_W-1:0] POS_SLASH_B = 5'd5;
  localparam logic [POS_W-1:0] POS_SPACE   = 5'd8;
  localparam logic [POS_W-1:0] POS_COLON_A = 5'd11;
  localparam logic [POS_W-1:0] POS_COLON_B = 5'd14;

  // calendar constants: years 2000..2099 counted from 1978-01-01
  localparam logic [6:0]  YEARS_TO_2000  = 7'd22;
  localparam logic [16:0] LEAPS_TO_2000  = 17'd5;
  localparam logic [16:0] DAYS_PER_YEAR  = 17'd365;
  localparam logic [6:0]  MAX_HOUR       = 7'd23;
  localparam logic [6:0]  MAX_MIN_SEC    = 7'd59;
  localparam logic [15:0] MAX_DAY_COUNT  = 16'd44559;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } dtdc_req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] day_count;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
  } dtdc_res_t;

  // field position to digit slot; separators are never stored
  function automatic logic [DIGIT_IDX_W-1:0] digit_index(input logic [POS_W-1:0] pos);
    logic [DIGIT_IDX_W-1:0] idx;
    begin
      case (pos)
        5'd0:    idx = 4'd0;
        5'd1:    idx = 4'd1;
        5'd3:    idx = 4'd2;
        5'd4:    idx = 4'd3;
        5'd6:    idx = 4'd4;
        5'd7:    idx = 4'd5;
        5'd9:    idx = 4'd6;
        5'd10:   idx = 4'd7;
        5'd12:   idx = 4'd8;
        5'd13:   idx = 4'd9;
        5'd15:   idx = 4'd10;
        5'd16:   idx = 4'd11;
        default: idx = 4'd0;
      endcase
      return idx;
    end
  endfunction

  // days in the year before the first of the month, non-leap
  function automatic logic [8:0] days_before_month(input logic [3:0] month);
    logic [8:0] d;
    begin
      case (month)
        4'd1:    d = 9'd0;
        4'd2:    d = 9'd31;
        4'd3:    d = 9'd59;
        4'd4:    d = 9'd90;
        4'd5:    d = 9'd120;
        4'd6:    d = 9'd151;
        4'd7:    d = 9'd181;
        4'd8:    d = 9'd212;
        4'd9:    d = 9'd243;
        4'd10:   d = 9'd273;
        4'd11:   d = 9'd304;
        4'd12:   d = 9'd334;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

  // days in the month, non-leap
  function automatic logic [4:0] month_length(input logic [3:0] month);
    logic [4:0] d;
    begin
      case (month)
        4'd2:                      d = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
        default:                   d = 5'd31;
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/date_text_to_day_count.sv -----
// date and time text parser producing a day count since 1978-01-01
`default_nettype none

// Takes one text character per request and, on the request marked
// end_of_text, returns one result: status, days since 1978-01-01 for year
// 2000+YY, and hour, minute and second. Leading blanks are skipped, up to
// 17 characters MM/DD/YY HH:MM:SS are collected, and CR, LF or NUL stops
// collection early. A new request is taken every cycle unless an
// end-marked request waits as described below. The result passes from the
// request register, where the character is parsed, through the snapshot
// register, where the calendar arithmetic runs, to the result register.
// Requests without the end mark keep flowing while a result waits; an
// end-marked request waits only while both the snapshot and the result
// registers are full and res_ready is low.
module date_text_to_day_count
  import dtdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire dtdc_req_t req,
  output logic           res_valid,
  input  wire logic      res_ready,
  output dtdc_res_t      res
);

  // request register
  logic      a_valid;
  dtdc_req_t a_req;

  // parse state
  logic [POS_W-1:0] char_position, char_position_next;
  logic             skipping_blanks, skipping_blanks_next;
  logic             collection_stopped, collection_stopped_next;
  logic             format_bad, format_bad_next;
  logic [3:0]       digit_store [DIGITS];
  logic [3:0]       digit_store_next [DIGITS];

  // snapshot register
  logic       b_valid;
  logic       b_ok;
  logic [3:0] b_digits [DIGITS];

  // handshake between stages
  logic res_free, b_free, b_move, a_move;

  assign res_free  = !res_valid || res_ready;
  assign b_move    = b_valid && res_free;
  assign b_free    = !b_valid || res_free;
  assign a_move    = a_valid && (!a_req.end_of_text || b_free);
  assign req_ready = !a_valid || a_move;

  // request register load
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_ready) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      a_req <= req;
    end
  end

  // character parse
  always_comb begin
    logic [7:0] c;
    c                       = a_req.char_in;
    char_position_next      = char_position;
    skipping_blanks_next    = skipping_blanks;
    collection_stopped_next = collection_stopped;
    format_bad_next         = format_bad;
    digit_store_next        = digit_store;
    if (!(skipping_blanks && (c == CHAR_SPACE || c == CHAR_TAB))) begin
      skipping_blanks_next = 1'b0;
      if (!collection_stopped && (char_position < POS_W'(TEXT_FIELD_CHARS))) begin
        if (c inside {CHAR_CR, CHAR_LF, CHAR_NUL}) begin
          collection_stopped_next = 1'b1;
        end else begin
          if (char_position inside {POS_SLASH_A, POS_SLASH_B}) begin
            if (c != CHAR_SLASH) format_bad_next = 1'b1;
          end else if (char_position == POS_SPACE) begin
            if (c != CHAR_SPACE) format_bad_next = 1'b1;
          end else if (char_position inside {POS_COLON_A, POS_COLON_B}) begin
            if (c != CHAR_COLON) format_bad_next = 1'b1;
          end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
            format_bad_next = 1'b1;
          end else begin
            digit_store_next[digit_index(char_position)] = c[3:0];
          end
          char_position_next = char_position + POS_W'(1);
        end
      end
    end
  end

  // parse state update, cleared after each end-marked request
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position      <= '0;
      skipping_blanks    <= 1'b1;
      collection_stopped <= 1'b0;
      format_bad         <= 1'b0;
    end else if (a_move) begin
      if (a_req.end_of_text) begin
        char_position      <= '0;
        skipping_blanks    <= 1'b1;
        collection_stopped <= 1'b0;
        format_bad         <= 1'b0;
      end else begin
        char_position      <= char_position_next;
        skipping_blanks    <= skipping_blanks_next;
        collection_stopped <= collection_stopped_next;
        format_bad         <= format_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      digit_store <= digit_store_next;
    end
  end

  // snapshot of a finished text
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid && a_req.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid && a_req.end_of_text) begin
      b_ok     <= (char_position_next >= POS_W'(TEXT_FIELD_CHARS)) && !format_bad_next;
      b_digits <= digit_store_next;
    end
  end

  // range checks and day count
  dtdc_res_t res_next;

  always_comb begin
    logic [6:0]  mo, da, yr, hh, mi, ss;
    logic        leap;
    logic [4:0]  dim;
    logic [16:0] days;
    mo   = 7'(b_digits[0]) * 7'd10 + 7'(b_digits[1]);
    da   = 7'(b_digits[2]) * 7'd10 + 7'(b_digits[3]);
    yr   = 7'(b_digits[4]) * 7'd10 + 7'(b_digits[5]);
    hh   = 7'(b_digits[6]) * 7'd10 + 7'(b_digits[7]);
    mi   = 7'(b_digits[8]) * 7'd10 + 7'(b_digits[9]);
    ss   = 7'(b_digits[10]) * 7'd10 + 7'(b_digits[11]);
    // every year 2000..2099 divisible by four is leap
    leap = (yr[1:0] == 2'b00);
    dim  = month_length(mo[3:0]);
    if (mo == 7'd2 && leap) dim = 5'd29;
    // leap days from 2000 through the year before: ceil(yr / 4)
    days = DAYS_PER_YEAR * 17'(yr + YEARS_TO_2000)
         + LEAPS_TO_2000
         + 17'((8'(yr) + 8'd3) >> 2)
         + 17'(days_before_month(mo[3:0]))
         + 17'((mo > 7'd2 && leap) ? 1'b1 : 1'b0)
         + 17'(da) - 17'd1;
    res_next = '0;
    res_next.status = 1'b1;
    if (b_ok && mo >= 7'd1 && mo <= 7'd12 && da >= 7'd1 && hh <= MAX_HOUR &&
        mi <= MAX_MIN_SEC && ss <= MAX_MIN_SEC && da <= 7'(dim)) begin
      res_next.status     = 1'b0;
      res_next.day_count  = days[15:0];
      res_next.hour_out   = hh[4:0];
      res_next.minute_out = mi[5:0];
      res_next.second_out = ss[5:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dtdc_checker.sv -----
// port-level checks for the date text parser, bound to the top level
`default_nettype none

module dtdc_checker
  import dtdc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      req_valid,
  input wire logic      req_ready,
  input wire dtdc_req_t req,
  input wire logic      res_valid,
  input wire logic      res_ready,
  input wire dtdc_res_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // an invalid result carries zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> res.day_count == '0 && res.hour_out == '0 &&
      res.minute_out == '0 && res.second_out == '0)
    else $error("invalid result with nonzero fields");

  // a valid result stays in range
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.status |-> res.day_count <= MAX_DAY_COUNT &&
      res.hour_out <= 5'd23 && res.minute_out <= 6'd59 && res.second_out <= 6'd59)
    else $error("valid result out of range");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result present after reset");

endmodule

bind date_text_to_day_count dtdc_checker u_dtdc_checker (.*);

`default_nettype wire
